// ----- rtl/rxtxmix_pkg.sv -----
// Package for the RX/TX frame mixer: defaults, flag type and saturating add.
package rxtxmix_pkg;

  localparam int TX_CAP_DEFAULT = 4096;
  localparam int RX_CAP_DEFAULT = 4096;

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;

  // Per-frame control flags.
  typedef struct packed {
    logic rx;
    logic mix;
    logic skip;
  } frame_flags_t;

  localparam frame_flags_t FLAGS_NONE = '{rx: 1'b0, mix: 1'b0, skip: 1'b0};
  localparam frame_flags_t FLAGS_SKIP = '{rx: 1'b0, mix: 1'b0, skip: 1'b1};

  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [16:0] sum;
    sum = 17'(a) + 17'(b);
    if (sum > 17'(SAMPLE_MAX)) begin
      return SAMPLE_MAX;
    end else if (sum < 17'(SAMPLE_MIN)) begin
      return SAMPLE_MIN;
    end else begin
      return sum[15:0];
    end
  endfunction

endpackage

// ----- rtl/rx_tx_frame_saturating_mixer.sv -----
// Top level of the RX/TX frame mixer: frame control, TX sample store and output stage.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one PCM sample per beat with its
//   direction (mode), frame-open flag (first) and the frame's length and format.
//   TX frames are written into the on-chip sample store; RX frames come out on
//   the output channel (out_valid/out_ready), one beat per kept sample, mixed
//   with the stored TX sample at the same position when the lengths match.
//   Configuration channel (cfg_valid/cfg_ready) writes recording_enable; every
//   write of 1 opens a new session (format lock, TX count, byte total cleared).
//   cfg_ready is always high; write it only while no sample is in flight.
// Timing:
//   An RX beat is registered in the middle stage and then in the output register
//   before its output handshake can happen.
//   Throughput is one sample per cycle while the receiver keeps up: the store is
//   read once per mixed RX beat and written once per TX beat, one port access per cycle.
//   A TX write lands before any later RX read, so no forwarding is needed.
// Reset and stalls:
//   rst clears enable, session state and both pipeline stages; the store
//   content is not cleared. A stalled receiver fills the output register and
//   then the middle stage; in_ready drops only once both are full.
module rx_tx_frame_saturating_mixer
  import rxtxmix_pkg::*;
#(
  parameter int TX_CAP = TX_CAP_DEFAULT,
  parameter int RX_CAP = RX_CAP_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               recording_enable,
  // input samples
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic signed [15:0] sample,
  input  logic               first,
  input  logic [15:0]        frame_length,
  input  logic [19:0]        sample_rate,
  input  logic [7:0]         channels,
  // mixed output
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] mixed_sample,
  output logic               last_of_frame,
  output logic               header_due,
  output logic [31:0]        bytes_total
);

  localparam int MAX_CAP = (TX_CAP > RX_CAP) ? TX_CAP : RX_CAP;
  localparam int CNT_W   = $clog2(MAX_CAP + 1);
  localparam int ADDR_W  = (TX_CAP > 1) ? $clog2(TX_CAP) : 1;
  localparam logic [15:0] TX_CAP_L = 16'(TX_CAP);
  localparam logic [15:0] RX_CAP_L = 16'(RX_CAP);

  // Session / frame state
  logic               rec_enable;
  logic [CNT_W-1:0]   tx_length;
  logic [19:0]        locked_rate;
  logic [7:0]         locked_channels;
  logic               header_done;
  logic [31:0]        byte_counter;
  logic [CNT_W-1:0]   frame_position;
  frame_flags_t       frame_flags;
  logic [CNT_W-1:0]   frame_kept;

  // Accept-cycle decode
  logic               in_accept;
  logic               cfg_accept;
  logic [CNT_W-1:0]   tx_clip;
  logic [CNT_W-1:0]   rx_clip;
  logic [CNT_W-1:0]   pos_eff;
  logic [CNT_W-1:0]   kept_eff;
  frame_flags_t       flags_eff;
  logic [CNT_W-1:0]   tx_length_next;
  logic [19:0]        locked_rate_next;
  logic [7:0]         locked_channels_next;
  logic               fmt_ok;
  logic               active;
  logic               emit;
  logic               store;
  logic [31:0]        byte_counter_next;

  // TX sample store
  logic signed [15:0] tx_store [TX_CAP];
  logic signed [15:0] rd_data;
  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_addr;

  // Middle stage (store read in flight)
  logic               s1_valid;
  logic               s1_free;
  logic signed [15:0] s1_sample;
  logic               s1_mix;
  logic               s1_last;
  logic               s1_hdr;
  logic [31:0]        s1_bytes;
  logic signed [15:0] s1_mixed;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid & cfg_ready;
  assign s1_free    = ~out_valid | out_ready;
  assign in_ready   = ~s1_valid | s1_free;
  assign in_accept  = in_valid & in_ready;

  assign tx_clip = (frame_length < TX_CAP_L) ? CNT_W'(frame_length) : CNT_W'(TX_CAP);
  assign rx_clip = (frame_length < RX_CAP_L) ? CNT_W'(frame_length) : CNT_W'(RX_CAP);

  // Frame open handling and per-sample decision
  always_comb begin
    pos_eff              = frame_position;
    kept_eff             = frame_kept;
    flags_eff            = frame_flags;
    tx_length_next       = tx_length;
    locked_rate_next     = locked_rate;
    locked_channels_next = locked_channels;
    fmt_ok               = 1'b0;
    if (first) begin
      pos_eff   = '0;
      kept_eff  = '0;
      flags_eff = FLAGS_SKIP;
      if (rec_enable) begin
        // an open lock takes this frame's format
        if (locked_rate == '0) begin
          locked_rate_next     = sample_rate;
          locked_channels_next = channels;
        end
        fmt_ok = (sample_rate == locked_rate_next) && (channels == locked_channels_next);
        if (fmt_ok) begin
          if (!mode) begin
            tx_length_next = tx_clip;
            kept_eff       = tx_clip;
            flags_eff      = FLAGS_NONE;
          end else begin
            kept_eff      = rx_clip;
            flags_eff     = FLAGS_NONE;
            flags_eff.rx  = 1'b1;
            flags_eff.mix = (tx_length == rx_clip);
          end
        end
      end
    end
    active            = rec_enable && !flags_eff.skip && (pos_eff < kept_eff);
    emit              = active && flags_eff.rx;
    store             = active && !flags_eff.rx;
    byte_counter_next = byte_counter + 32'd2;
  end

  // Kept positions are below the TX capacity whenever the store is touched.
  assign mem_addr = pos_eff[ADDR_W-1:0];
  assign mem_we   = in_accept && store;
  assign mem_re   = in_accept && emit && flags_eff.mix;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tx_store[mem_addr] <= sample;
    end
    if (mem_re) begin
      rd_data <= tx_store[mem_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_enable      <= 1'b0;
      tx_length       <= '0;
      locked_rate     <= '0;
      locked_channels <= '0;
      header_done     <= 1'b0;
      byte_counter    <= '0;
      frame_position  <= '0;
      frame_flags     <= FLAGS_NONE;
      frame_kept      <= '0;
    end else if (cfg_accept) begin
      rec_enable <= recording_enable;
      if (recording_enable) begin
        tx_length       <= '0;
        locked_rate     <= '0;
        locked_channels <= '0;
        header_done     <= 1'b0;
        byte_counter    <= '0;
        frame_position  <= '0;
        frame_flags     <= FLAGS_NONE;
        frame_kept      <= '0;
      end
    end else if (in_accept) begin
      tx_length       <= tx_length_next;
      locked_rate     <= locked_rate_next;
      locked_channels <= locked_channels_next;
      frame_flags     <= flags_eff;
      frame_kept      <= kept_eff;
      frame_position  <= active ? pos_eff + CNT_W'(1) : pos_eff;
      if (emit) begin
        byte_counter <= byte_counter_next;
        header_done  <= 1'b1;
      end
    end
  end

  // Middle stage: holds the beat while the store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept && emit) begin
      s1_valid <= 1'b1;
    end else if (s1_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      s1_sample <= sample;
      s1_mix    <= flags_eff.mix;
      s1_last   <= (pos_eff + CNT_W'(1)) == kept_eff;
      s1_hdr    <= ~header_done;
      s1_bytes  <= byte_counter_next;
    end
  end

  assign s1_mixed = s1_mix ? sat_add(s1_sample, rd_data) : s1_sample;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_free) begin
      mixed_sample  <= s1_mixed;
      last_of_frame <= s1_last;
      header_due    <= s1_hdr;
      bytes_total   <= s1_bytes;
    end
  end

endmodule

// ----- rtl/rxtxmix_checker.sv -----
// Port-level checker for the RX/TX frame mixer, bound to the top level.
module rxtxmix_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] mixed_sample,
  input logic               header_due,
  input logic [31:0]        bytes_total
);

  // output beat held while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mixed_sample) && $stable(bytes_total))
    else $error("output beat changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // first RX beat of a session carries the first two bytes
  a_hdr_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_due |-> bytes_total == 32'd2)
    else $error("header beat with wrong byte total");

  // a fresh output beat traces back to an accepted input
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("output beat without accepted input");

endmodule

bind rx_tx_frame_saturating_mixer rxtxmix_checker u_rxtxmix_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .mixed_sample (mixed_sample),
  .header_due   (header_due),
  .bytes_total  (bytes_total)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the RX/TX frame saturating mixer.
module tb;
  import rxtxmix_pkg::*;

  localparam int TX_CAP = TX_CAP_DEFAULT;
  localparam int RX_CAP = RX_CAP_DEFAULT;
  // The directed TX frame fills store positions 0..STORE_SPAN-1. Random RX frames
  // never read a position past that span, so no unwritten store entry is read.
  localparam int STORE_SPAN = 16;
  localparam int RX_RUN_MAX = 13;  // most beats sent for frames longer than the span
  localparam int NOISE_MAX = 3;    // most loose beats that may trail a frame
  localparam int DRAIN_CYCLES = 8; // settling wait after the queues drain
  localparam int PHASE_ITEMS = 350;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] sample;
    logic               first;
    logic [15:0]        len;
    logic [19:0]        rate;
    logic [7:0]         ch;
  } pcm_beat_t;

  typedef struct packed {
    logic signed [15:0] mixed;
    logic               last;
    logic               hdr;
    logic [31:0]        total;
  } mix_result_t;

  // DUT signals; every input starts at a known value
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               recording_enable = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               mode = 1'b0;
  logic signed [15:0] sample = '0;
  logic               first = 1'b0;
  logic [15:0]        frame_length = '0;
  logic [19:0]        sample_rate = '0;
  logic [7:0]         channels = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] mixed_sample;
  logic               last_of_frame;
  logic               header_due;
  logic [31:0]        bytes_total;

  rx_tx_frame_saturating_mixer #(
    .TX_CAP(TX_CAP),
    .RX_CAP(RX_CAP)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .recording_enable(recording_enable),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .sample(sample),
    .first(first),
    .frame_length(frame_length),
    .sample_rate(sample_rate),
    .channels(channels),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .mixed_sample(mixed_sample),
    .last_of_frame(last_of_frame),
    .header_due(header_due),
    .bytes_total(bytes_total)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus and scoreboard storage
  pcm_beat_t   pending_q[$];
  mix_result_t mix_expect_q[$];
  int          send_idle_pct = 32;
  int          recv_idle_pct = 72;
  int          err_count = 0;
  logic        in_taken = 1'b0;   // input beat accepted at the last rising edge
  pcm_beat_t   next_beat;
  pcm_beat_t   seen_beat;
  mix_result_t pred_r;
  mix_result_t exp_r;

  // Shadow copy of the mixer state
  logic               rec_on;
  logic signed [15:0] tx_mem [TX_CAP];
  int                 tx_count;
  logic [19:0]        lock_rate;
  logic [7:0]         lock_ch;
  logic               hdr_sent;
  logic [31:0]        byte_sum;
  int                 frame_pos;
  int                 frame_keep;
  frame_flags_t       frame_state;

  // New session: format lock, TX count, header flag and byte total cleared,
  // any frame in progress dropped. Store content survives.
  task automatic session_clear();
    tx_count = 0;
    lock_rate = '0;
    lock_ch = '0;
    hdr_sent = 1'b0;
    byte_sum = '0;
    frame_pos = 0;
    frame_keep = 0;
    frame_state = FLAGS_NONE;
  endtask

  // Advance the shadow state by one accepted beat; returns 1 with the
  // expected output beat when this input produces one.
  function automatic bit predict_mix(input pcm_beat_t b, output mix_result_t r);
    logic signed [16:0] acc;
    r = '0;
    if (b.first) begin
      frame_pos = 0;
      frame_keep = 0;
      frame_state = FLAGS_SKIP;
      if (rec_on) begin
        // unknown rate keeps the lock open: each new frame relocks
        if (lock_rate == '0) begin
          lock_rate = b.rate;
          lock_ch = b.ch;
        end
        if (b.rate == lock_rate && b.ch == lock_ch) begin
          if (!b.mode) begin
            tx_count = (int'(b.len) < TX_CAP) ? int'(b.len) : TX_CAP;
            frame_keep = tx_count;
            frame_state = FLAGS_NONE;
          end else begin
            frame_keep = (int'(b.len) < RX_CAP) ? int'(b.len) : RX_CAP;
            frame_state = '{rx: 1'b1, mix: (tx_count == frame_keep), skip: 1'b0};
          end
        end
      end
    end
    // disabled, skipped frame, or beats past the clipped length: dropped
    if (!rec_on || frame_state.skip || frame_pos >= frame_keep) begin
      return 1'b0;
    end
    if (!frame_state.rx) begin
      if (frame_pos < TX_CAP) begin
        tx_mem[frame_pos] = b.sample;
      end
      frame_pos++;
      return 1'b0;
    end
    acc = b.sample;
    if (frame_state.mix && frame_pos < TX_CAP) begin
      acc = b.sample + tx_mem[frame_pos];
      if (acc > SAMPLE_MAX) begin
        acc = SAMPLE_MAX;
      end else if (acc < SAMPLE_MIN) begin
        acc = SAMPLE_MIN;
      end
    end
    byte_sum = byte_sum + 32'd2;  // wraps at 2^32
    r.mixed = acc[15:0];
    r.last = (frame_pos + 1 == frame_keep);
    r.hdr = !hdr_sent;
    r.total = byte_sum;
    hdr_sent = 1'b1;
    frame_pos++;
    return 1'b1;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t ns: %s expected %h got %h", $time, what, want, got);
    end
  endtask

  // Driver: inputs move on the falling edge only. A held beat is replaced
  // only after the rising edge that accepted it.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = pending_q.pop_front();
          in_valid <= 1'b1;
          mode <= next_beat.mode;
          sample <= next_beat.sample;
          first <= next_beat.first;
          frame_length <= next_beat.len;
          sample_rate <= next_beat.rate;
          channels <= next_beat.ch;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: everything sampled on the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
      rec_on = 1'b0;
      session_clear();
    end else begin
      in_taken <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        rec_on = recording_enable;
        if (recording_enable) begin
          session_clear();
        end
      end
      if (in_valid && in_ready) begin
        seen_beat.mode = mode;
        seen_beat.sample = sample;
        seen_beat.first = first;
        seen_beat.len = frame_length;
        seen_beat.rate = sample_rate;
        seen_beat.ch = channels;
        if (predict_mix(seen_beat, pred_r)) begin
          mix_expect_q.push_back(pred_r);
        end
      end
      if (out_valid && out_ready) begin
        if (mix_expect_q.size() == 0) begin
          err_count++;
          $display("%0t ns: output beat with nothing expected, mixed_sample %h",
                   $time, mixed_sample);
        end else begin
          exp_r = mix_expect_q.pop_front();
          check_field("mixed_sample", exp_r.mixed, mixed_sample);
          check_field("last_of_frame", exp_r.last, last_of_frame);
          check_field("header_due", exp_r.hdr, header_due);
          check_field("bytes_total", exp_r.total, bytes_total);
        end
      end
    end
  end

  // ---- stimulus helpers ----

  // PCM value, often a full-scale extreme so sums saturate
  function automatic logic signed [15:0] pick_pcm();
    if ($urandom_range(99) < 20) begin
      return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
    end
    return 16'($urandom);
  endfunction

  // Frame length: mostly within the store span, some full-range, some at or near the cap
  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      return 16'($urandom_range(0, STORE_SPAN));
    end else if (r < 85) begin
      return 16'($urandom);
    end
    case ($urandom_range(4))
      0: return 16'(TX_CAP - 1);
      1: return 16'(TX_CAP);
      2: return 16'(TX_CAP + 1);
      3: return 16'hFFFF;
      default: return 16'(STORE_SPAN + 1);
    endcase
  endfunction

  // Beats for a frame: full, short, one extra past the end, or 1..RX_RUN_MAX if long
  function automatic int pick_count(input logic [15:0] len);
    int r;
    int n;
    if (len > STORE_SPAN) begin
      return $urandom_range(1, RX_RUN_MAX);
    end
    r = $urandom_range(99);
    if (r < 70) begin
      n = len;
    end else if (r < 85) begin
      n = $urandom_range(0, len);
    end else begin
      n = len + 1;
    end
    return (n == 0) ? 1 : n;
  endfunction

  task automatic queue_beat(input logic md, input logic signed [15:0] smp,
                            input logic fst, input logic [15:0] len,
                            input logic [19:0] rate, input logic [7:0] ch);
    pcm_beat_t b;
    b.mode = md;
    b.sample = smp;
    b.first = fst;
    b.len = len;
    b.rate = rate;
    b.ch = ch;
    pending_q.push_back(b);
  endtask

  task automatic queue_frame(input logic md, input logic [15:0] len,
                             input logic [19:0] rate, input logic [7:0] ch,
                             input int n);
    for (int i = 0; i < n; i++) begin
      queue_beat(md, pick_pcm(), i == 0, len, rate, ch);
    end
  endtask

  // Mostly well-formed frames in the session format; the rest are frames in
  // another format, rate-0 frames and loose beats. Only well-formed beats count.
  task automatic queue_random_phase(input int target, input logic [19:0] f_rate,
                                    input logic [7:0] f_ch);
    int          counted;
    int          kind;
    int          n;
    logic        md;
    logic [15:0] len;
    logic [15:0] last_tx;
    logic [19:0] x_rate;
    logic [7:0]  x_ch;
    counted = 0;
    last_tx = '0;
    while (counted < target) begin
      // the opening frame of a phase is in the session format and locks it if still open
      kind = (counted == 0) ? 0 : $urandom_range(99);
      md = 1'($urandom_range(1));
      if (kind < 80) begin
        len = pick_len();
        // reuse the TX length so RX frames often mix
        if (md && $urandom_range(99) < 30) begin
          len = last_tx;
        end
        if (!md) begin
          last_tx = len;
        end
        n = pick_count(len);
        queue_frame(md, len, f_rate, f_ch, n);
        counted += n;
      end else if (kind < 90) begin
        case ($urandom_range(2))
          0: begin
            x_rate = f_rate ^ 20'($urandom_range(1, 20'hFFFFF));
            x_ch = f_ch;
          end
          1: begin
            x_rate = f_rate;
            x_ch = f_ch ^ 8'($urandom_range(1, 255));
          end
          default: begin
            x_rate = 20'($urandom);
            x_ch = 8'($urandom);
          end
        endcase
        queue_frame(md, pick_len(), x_rate, x_ch, $urandom_range(1, 4));
      end else begin
        len = pick_len();
        queue_frame(md, len, '0, f_ch, pick_count(len));
      end
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, NOISE_MAX)) begin
          queue_beat(1'($urandom_range(1)), pick_pcm(), 1'b0, 16'($urandom),
                     20'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  // Wait until every queued beat is in and every output beat is out,
  // then give a trailing TX beat time to land.
  task automatic settle();
    while (pending_q.size() != 0 || in_valid || mix_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    recording_enable <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---- test sequence ----
  initial begin
    logic [19:0] fmt_rate;
    logic [7:0]  fmt_ch;
    fmt_rate = 20'($urandom_range(1, 20'hFFFFF));
    fmt_ch = 8'($urandom);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // disabled after reset: frame opened now is ignored
    queue_beat(1'b1, pick_pcm(), 1'b1, 16'd2, fmt_rate, fmt_ch);
    queue_beat(1'b1, pick_pcm(), 1'b0, 16'd2, fmt_rate, fmt_ch);
    settle();
    write_enable(1'b1);

    // stray beat before any frame opens
    queue_beat(1'b1, pick_pcm(), 1'b0, 16'd4, fmt_rate, fmt_ch);
    // TX fill of the store span; rate 0 leaves the format lock open
    queue_beat(1'b0, SAMPLE_MAX, 1'b1, 16'(STORE_SPAN), '0, fmt_ch);
    queue_beat(1'b0, SAMPLE_MIN, 1'b0, 16'(STORE_SPAN), '0, fmt_ch);
    queue_beat(1'b0, -16'sd1, 1'b0, 16'(STORE_SPAN), '0, fmt_ch);
    for (int i = 3; i < STORE_SPAN; i++) begin
      queue_beat(1'b0, pick_pcm(), 1'b0, 16'(STORE_SPAN), '0, fmt_ch);
    end
    // RX of matching length locks the format and mixes: both saturations, then -1
    queue_beat(1'b1, SAMPLE_MAX, 1'b1, 16'(STORE_SPAN), fmt_rate, fmt_ch);
    queue_beat(1'b1, SAMPLE_MIN, 1'b0, 16'(STORE_SPAN), fmt_rate, fmt_ch);
    queue_beat(1'b1, 16'sd0, 1'b0, 16'(STORE_SPAN), fmt_rate, fmt_ch);
    // format mismatch: skipped whole
    queue_beat(1'b1, pick_pcm(), 1'b1, 16'd4, fmt_rate ^ 20'h1, fmt_ch);
    // over-long RX, clipped, no mix
    queue_frame(1'b1, 16'hFFFF, fmt_rate, fmt_ch, 2);
    // over-long TX sets the count to the cap; short frame keeps older store data
    queue_frame(1'b0, 16'hFFFF, fmt_rate, fmt_ch, 1);
    queue_frame(1'b1, 16'(TX_CAP + 4), fmt_rate, fmt_ch, 2);
    // zero-length TX then zero-length RX: nothing emitted
    queue_frame(1'b0, 16'd0, fmt_rate, fmt_ch, 1);
    queue_frame(1'b1, 16'd0, fmt_rate, fmt_ch, 1);

    queue_random_phase(PHASE_ITEMS, fmt_rate, fmt_ch);
    settle();

    // disabled stretch, then a fresh session
    write_enable(1'b0);
    queue_random_phase(30, 20'($urandom), 8'($urandom));
    settle();
    write_enable(1'b1);
    send_idle_pct = 72;
    recv_idle_pct = 32;
    queue_random_phase(PHASE_ITEMS, 20'($urandom_range(1, 20'hFFFFF)), 8'($urandom));
    settle();

    // write of 1 while already enabled restarts the session
    write_enable(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_phase(PHASE_ITEMS, 20'($urandom_range(1, 20'hFFFFF)), 8'($urandom));
    settle();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rxtxmix_pkg.sv
rtl/rx_tx_frame_saturating_mixer.sv
rtl/rxtxmix_checker.sv
tb/tb.sv
